>>> sv/fir_lc_pkg.sv
`default_nettype none

package fir_lc_pkg;

    // field widths of the channels
    localparam int DATA_W = 16;
    localparam int IDX_W  = 4;
    localparam int RES_W  = 35;

    // default filter length
    localparam int TAPS_DEFAULT = 12;

    // radix-16 digits of the sample word, least significant first
    localparam int DIGIT_W   = 4;
    localparam int N_DIGITS  = DATA_W / DIGIT_W;
    localparam int DIG_SEL_W = $clog2(N_DIGITS);
    localparam logic [DIG_SEL_W-1:0] DIG_LAST = DIG_SEL_W'(N_DIGITS - 1);

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [RES_W-1:0]  t_result;

    // control of the digit-serial multiply-accumulate unit
    typedef struct packed {
        logic                 en;
        logic                 clr;
        logic [DIG_SEL_W-1:0] digit;
    } t_mac_ctrl;

endpackage

`default_nettype wire

>>> sv/fir_lc_if.sv
`default_nettype none

interface fir_lc_in_if;
    import fir_lc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [IDX_W-1:0]         tap_index;
    logic signed [DATA_W-1:0] value;
    logic                     last_sample;

    modport source (output valid, operation, tap_index, value, last_sample, input ready);
    modport sink   (input valid, operation, tap_index, value, last_sample, output ready);
endinterface

interface fir_lc_out_if;
    import fir_lc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_value;
    logic                    last_of_run;

    modport source (output valid, result_value, last_of_run, input ready);
    modport sink   (input valid, result_value, last_of_run, output ready);
endinterface

`default_nettype wire

>>> sv/fir_lc_mac.sv
`default_nettype none

module fir_lc_mac (
    input  logic                          i_clk,
    input  fir_lc_pkg::t_mac_ctrl         i_ctrl,
    input  fir_lc_pkg::t_sample           i_coef,
    input  fir_lc_pkg::t_sample           i_sample,
    output fir_lc_pkg::t_result           o_acc
);
    import fir_lc_pkg::*;

    localparam int SH_W = $clog2(RES_W);

    logic [DIGIT_W-1:0]             dig_raw;
    logic signed [DIGIT_W:0]        dig;
    logic signed [DATA_W+DIGIT_W:0] pp;
    t_result                        pp_ext;
    t_result                        pp_sh;
    logic [SH_W-1:0]                shamt;
    t_result                        r_acc;
    t_result                        n_acc;

    // top digit carries the sign of the sample
    always_comb begin
        dig_raw = i_sample[i_ctrl.digit * DIGIT_W +: DIGIT_W];
        dig     = {(i_ctrl.digit == DIG_LAST) ? dig_raw[DIGIT_W-1] : 1'b0, dig_raw};
        pp      = i_coef * dig;
        pp_ext  = RES_W'(pp);
        shamt   = SH_W'(i_ctrl.digit * DIGIT_W);
        pp_sh   = pp_ext << shamt;
        n_acc   = (i_ctrl.clr ? t_result'('0) : r_acc) + pp_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

>>> sv/fir_linear_convolution_core.sv
// a sample transaction passes the fetch, multiply-accumulate and output states before its result shows
// a new sample is not taken until the previous run is over; the run is paced by the radix-16 multiply-accumulate
//   (four digits per tap, one shared unit) and waits while the output stalls; each tail output repeats the pass
// a coefficient load gives no result
// reset (synchronous, active low) clears the coefficient valid bits, the delay line and all control
`default_nettype none

module fir_linear_convolution_core #(
    parameter int TAPS = fir_lc_pkg::TAPS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fir_lc_in_if.sink            i_in,
    fir_lc_out_if.source         o_out
);
    import fir_lc_pkg::*;

    // address and counter widths follow the filter length
    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = AW + DIG_SEL_W;
    localparam logic [CW-1:0] CNT_LAST  = CW'(N_DIGITS * TAPS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(TAPS - 1);
    localparam logic [AW-1:0] TAIL_N    = AW'(TAPS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_MAC,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_tail;
    logic            r_last;
    logic [AW-1:0]   r_rd_addr;
    logic            r_out_vld;
    t_result         r_out_val;
    logic            r_out_last;

    // coefficient memory with a valid bit per entry, so reset reads as zero
    t_sample         coef_mem [TAPS];
    logic [TAPS-1:0] r_coef_vld;
    t_sample         r_coef;

    // sample window: entry 0 is the current sample, the rest is the delay line
    t_sample         r_win [TAPS];
    t_sample         n_win [TAPS];

    logic            in_fire;
    logic            smp_fire;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic            out_free;
    logic            tail_more;
    logic            run_end;
    logic            win_clr;
    logic            win_shift;
    logic            win_rot;
    t_sample         shift_val;
    t_mac_ctrl       mac_ctrl;
    t_result         mac_acc;

    // input handshake: items are taken only between outputs
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && (r_state == S_IDLE);
    assign smp_fire   = in_fire && (i_in.operation == OP_SAMPLE);

    // loads beyond the table are dropped
    assign wr_en   = in_fire && (i_in.operation == OP_LOAD) && (int'(i_in.tap_index) < TAPS);
    assign wr_addr = AW'(i_in.tap_index);

    // coefficient 0 is fetched in the fetch state, the next one on the last digit of each tap
    assign rd_en = (r_state == S_FETCH)
                || ((r_state == S_MAC) && (r_cnt[DIG_SEL_W-1:0] == DIG_LAST));

    // output register frees up in the same cycle it is taken
    assign out_free  = !r_out_vld || o_out.ready;
    assign tail_more = r_last && (r_tail != '0);
    assign run_end   = (r_state == S_OUT) && out_free && !tail_more;

    // window control: new sample in, zero in for a tail tick, rotate once per tap, clear at the end of a last run
    assign win_clr   = run_end && r_last;
    assign win_shift = smp_fire || ((r_state == S_OUT) && out_free && tail_more);
    assign win_rot   = (r_state == S_MAC) && (r_cnt[DIG_SEL_W-1:0] == DIG_LAST);
    assign shift_val = smp_fire ? t_sample'(i_in.value) : t_sample'('0);

    always_comb begin
        n_win = r_win;
        priority if (win_clr) begin
            n_win = '{default: '0};
        end else if (win_shift) begin
            for (int i = TAPS - 1; i > 0; i--) begin
                n_win[i] = r_win[i-1];
            end
            n_win[0] = shift_val;
        end else if (win_rot) begin
            for (int i = 0; i < TAPS - 1; i++) begin
                n_win[i] = r_win[i+1];
            end
            n_win[TAPS-1] = r_win[0];
        end else begin
            n_win = r_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '{default: '0};
        end else begin
            r_win <= n_win;
        end
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            coef_mem[wr_addr] <= t_sample'(i_in.value);
        end
        if (rd_en) begin
            r_coef <= r_coef_vld[r_rd_addr] ? coef_mem[r_rd_addr] : t_sample'('0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
        end else if (wr_en) begin
            r_coef_vld[wr_addr] <= 1'b1;
        end
    end

    // digit-serial multiply-accumulate, cleared on the first digit of tap 0
    always_comb begin
        mac_ctrl.en    = (r_state == S_MAC);
        mac_ctrl.clr   = (r_cnt == '0);
        mac_ctrl.digit = r_cnt[DIG_SEL_W-1:0];
    end

    fir_lc_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_coef   (r_coef),
        .i_sample (r_win[0]),
        .o_acc    (mac_acc)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_tail     <= '0;
            r_last     <= 1'b0;
            r_rd_addr  <= '0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            // drop the taken output unless a new one is loaded this cycle
            if (o_out.ready && !((r_state == S_OUT) && out_free)) begin
                r_out_vld <= 1'b0;
            end
            if (rd_en) begin
                r_rd_addr <= (r_rd_addr == ADDR_LAST) ? '0 : r_rd_addr + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (smp_fire) begin
                        r_state   <= S_FETCH;
                        r_rd_addr <= '0;
                        r_last    <= i_in.last_sample;
                        r_tail    <= TAIL_N;
                    end
                end
                S_FETCH: begin
                    r_state <= S_MAC;
                    r_cnt   <= '0;
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_val  <= mac_acc;
                        r_out_last <= r_last && (r_tail == '0);
                        if (tail_more) begin
                            // coefficient 0 is already fetched after the wrap
                            r_tail  <= r_tail - 1'b1;
                            r_cnt   <= '0;
                            r_state <= S_MAC;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.result_value = r_out_val;
    assign o_out.last_of_run  = r_out_last;

endmodule

`default_nettype wire
